FILE: hdl/crcpf_pkg.sv
// ============================================================================
// crcpf_pkg
// Types, constants and the CRC step shared by the packet framer modules.
// ============================================================================
package crcpf_pkg;

    typedef enum logic [0:0] {
        OP_BEGIN   = 1'b0,
        OP_PAYLOAD = 1'b1
    } opcode_t;

    // Position in the framed byte sequence: start string, length, body
    // (descriptor or payload byte), CRC and stop string.
    typedef logic [3:0] pos_t;

    localparam pos_t POS_START0 = 4'd0;
    localparam pos_t POS_START1 = 4'd1;
    localparam pos_t POS_START2 = 4'd2;
    localparam pos_t POS_LEN_LO = 4'd3;
    localparam pos_t POS_LEN_HI = 4'd4;
    localparam pos_t POS_BODY   = 4'd5;
    localparam pos_t POS_CRC_LO = 4'd6;
    localparam pos_t POS_CRC_HI = 4'd7;
    localparam pos_t POS_STOP0  = 4'd8;
    localparam pos_t POS_STOP1  = 4'd9;
    localparam pos_t POS_STOP2  = 4'd10;

    localparam logic [7:0]  START_OUTER = 8'h3E;  // '>'
    localparam logic [7:0]  START_MID   = 8'h2A;  // '*'
    localparam logic [7:0]  STOP_OUTER  = 8'h3C;  // '<'
    localparam logic [7:0]  STOP_MID    = 8'h23;  // '#'
    localparam logic [15:0] CRC_INIT    = 16'h00FF;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One unit of work for the back end.
    typedef struct packed {
        logic        is_begin;   // emit header before the body byte
        logic        trailer;    // append CRC and stop string after the body
        logic [7:0]  body;       // descriptor or payload byte
        logic [15:0] length;
        logic [15:0] crc;
    } cmd_t;

    // Reflected CCITT CRC-16, one byte per call.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
        logic [7:0]  d;
        logic [15:0] r;
        d = data ^ crc[7:0];
        d = d ^ {d[3:0], 4'b0000};
        r = {d, crc[15:8]};
        r = r ^ {12'h000, d[7:4]};
        r = r ^ {5'b00000, d, 3'b000};
        return r;
    endfunction

endpackage

FILE: hdl/crcpf_if.sv
// ============================================================================
// crcpf_if
// Valid/ready channels for packet framer input items and output bytes.
// ============================================================================
interface crcpf_in_if import crcpf_pkg::*; ();
    logic        valid;
    logic        ready;
    opcode_t     opcode;
    logic [7:0]  payload_byte;
    logic [15:0] packet_length;
    logic [7:0]  descriptor;

    modport source (output valid, output opcode, output payload_byte,
                    output packet_length, output descriptor, input ready);
    modport sink   (input valid, input opcode, input payload_byte,
                    input packet_length, input descriptor, output ready);
endinterface

interface crcpf_out_if ();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;

    modport source (output valid, output out_byte, output last_of_run,
                    output frame_end, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input frame_end, output ready);
endinterface

FILE: hdl/crcpf_front.sv
// ============================================================================
// crcpf_front
// Accepts items, tracks packet state and the CRC, and queues commands.
// ============================================================================
module crcpf_front import crcpf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    crcpf_in_if.sink         pkt,
    input  logic             queue_full,
    output logic             push,
    output cmd_t             push_cmd
);

    logic        in_packet_reg, in_packet_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] crc_reg, crc_next;
    logic        accept;
    logic        last_byte;
    logic [15:0] crc_stepped;

    assign pkt.ready   = !queue_full;
    assign accept      = pkt.valid && pkt.ready;
    assign crc_stepped = crc_step(crc_reg, pkt.payload_byte);
    assign last_byte   = (bytes_left_reg == 16'd1);

    always_comb
    begin
        in_packet_next  = in_packet_reg;
        bytes_left_next = bytes_left_reg;
        crc_next        = crc_reg;
        push            = 1'b0;
        push_cmd        = '0;
        if (accept)
        begin
            if (pkt.opcode == OP_BEGIN)
            begin
                // A begin abandons any open packet.
                push              = 1'b1;
                push_cmd.is_begin = 1'b1;
                push_cmd.trailer  = (pkt.packet_length == 16'd0);
                push_cmd.body     = pkt.descriptor;
                push_cmd.length   = pkt.packet_length;
                push_cmd.crc      = CRC_INIT;
                in_packet_next    = (pkt.packet_length != 16'd0);
                bytes_left_next   = pkt.packet_length;
                crc_next          = CRC_INIT;
            end
            else if (in_packet_reg)
            begin
                push              = 1'b1;
                push_cmd.is_begin = 1'b0;
                push_cmd.trailer  = last_byte;
                push_cmd.body     = pkt.payload_byte;
                push_cmd.crc      = crc_stepped;
                in_packet_next    = !last_byte;
                bytes_left_next   = bytes_left_reg - 16'd1;
                crc_next          = crc_stepped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg  <= 1'b0;
            bytes_left_reg <= '0;
            crc_reg        <= CRC_INIT;
        end
        else
        begin
            in_packet_reg  <= in_packet_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
        end
    end

endmodule

FILE: hdl/crcpf_queue.sv
// ============================================================================
// crcpf_queue
// Short command queue between the front end and the byte sequencer.
// ============================================================================
module crcpf_queue import crcpf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t                slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/crcpf_back.sv
// ============================================================================
// crcpf_back
// Byte sequencer: walks each command through the frame byte positions.
// ============================================================================
module crcpf_back import crcpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cmd_t      head_cmd,
    output logic      pop,
    crcpf_out_if.source stream
);

    cmd_t       cmd_reg;
    pos_t       pos_reg;
    logic       busy_reg;
    logic       oval_reg;
    logic [7:0] obyte_reg;
    logic       olast_reg;
    logic       oend_reg;

    logic       can_emit;
    logic       done;
    pos_t       end_pos;
    logic [7:0] cur_byte;

    assign end_pos  = cmd_reg.trailer ? POS_STOP2 : POS_BODY;
    assign can_emit = busy_reg && (!oval_reg || stream.ready);
    assign done     = can_emit && (pos_reg == end_pos);
    // Load the next command in the same cycle the last byte goes out.
    assign pop      = head_valid && (!busy_reg || done);

    always_comb
    begin
        case (pos_reg)
            POS_START0: cur_byte = START_OUTER;
            POS_START1: cur_byte = START_MID;
            POS_START2: cur_byte = START_OUTER;
            POS_LEN_LO: cur_byte = cmd_reg.length[7:0];
            POS_LEN_HI: cur_byte = cmd_reg.length[15:8];
            POS_BODY:   cur_byte = cmd_reg.body;
            POS_CRC_LO: cur_byte = cmd_reg.crc[7:0];
            POS_CRC_HI: cur_byte = cmd_reg.crc[15:8];
            POS_STOP0:  cur_byte = STOP_OUTER;
            POS_STOP1:  cur_byte = STOP_MID;
            POS_STOP2:  cur_byte = STOP_OUTER;
            default:    cur_byte = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= POS_START0;
            oval_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= head_cmd.is_begin ? POS_START0 : POS_BODY;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            else if (can_emit)
            begin
                pos_reg <= pos_reg + 1'b1;
            end

            if (can_emit)
            begin
                oval_reg <= 1'b1;
            end
            else if (stream.ready)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head_cmd;
        end
        if (can_emit)
        begin
            obyte_reg <= cur_byte;
            olast_reg <= (pos_reg == end_pos);
            oend_reg  <= (pos_reg == POS_STOP2);
        end
    end

    assign stream.valid       = oval_reg;
    assign stream.out_byte    = obyte_reg;
    assign stream.last_of_run = olast_reg;
    assign stream.frame_end   = oend_reg;

endmodule

FILE: hdl/crc16_packet_framer_core.sv
// ============================================================================
// crc16_packet_framer_core
// Frames byte packets with start string, length, descriptor, CRC-16, stop.
// ============================================================================
// Usage:
// The pkt channel takes one item per cycle; pkt.ready drops only while
// the four-entry command queue between the front end and the sequencer
// is full. A begin item opens a frame and yields six bytes (eleven when
// the length is zero); a payload item inside a packet yields its byte,
// plus CRC and stop string when it is the last. A payload item outside a
// packet is accepted and dropped. While the receiver is ready, the stream
// channel delivers one framed byte per cycle and payload items stream at
// one per cycle. last_of_run marks the final byte caused by an item and
// frame_end the closing stop byte. The first byte of an item passes
// through the command queue, the sequencer's command register and the
// output register. The sequencer loads a new command as the old one ends.
// When the receiver stalls, the output register holds its byte, the
// sequencer waits and the queue fills before the input is held off.
// Reset clears the packet state, sets the CRC to 0x00FF and empties the
// queue and the output register.
// ============================================================================
module crc16_packet_framer_core import crcpf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    crcpf_in_if.sink      pkt,
    crcpf_out_if.source   stream
);

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    crcpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt        (pkt),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    crcpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    crcpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .stream     (stream)
    );

endmodule

FILE: hdl/crcpf_checker.sv
// ============================================================================
// crcpf_checker
// Port-level checks of the packet framer output stream.
// ============================================================================
module crcpf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       frame_end
);

    localparam logic [7:0] STOP_CHAR = 8'h3C;

    // A stalled byte stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(last_of_run) && $stable(frame_end))
        else $error("stalled output byte changed");

    // The frame closes on the final byte of an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> last_of_run)
        else $error("frame end without last_of_run");

    // The closing byte is the stop character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> out_byte == STOP_CHAR)
        else $error("frame end on a byte other than the stop character");

    // Nothing is offered as reset is released.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind crc16_packet_framer_core crcpf_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (stream.valid),
    .out_ready   (stream.ready),
    .out_byte    (stream.out_byte),
    .last_of_run (stream.last_of_run),
    .frame_end   (stream.frame_end)
);

FILE: tb/crc16_packet_framer_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// crc16_packet_framer_core_test
// Checks the framed byte stream against a predictor of the framer.
// ============================================================================
// A short directed sequence covers zero-length frames, the length and
// descriptor extremes, stray payload bytes and abandoned packets. A random
// mix of packets follows, mostly well formed, under four idling phases.
// A scoreboard predicts every framed byte, including the CRC-16 trailer,
// and compares each delivered byte with the oldest prediction.
// ============================================================================
module crc16_packet_framer_core_test;
    import crcpf_pkg::*;

    localparam int ITEM_TARGET = 310;

    typedef struct {
        logic [7:0] value;
        logic       last_of_run;
        logic       frame_end;
    } framed_byte_t;

    class framer_scoreboard;
        framed_byte_t pending_bytes[$];
        logic         in_packet;
        logic [15:0]  bytes_left;
        logic [15:0]  running_crc;
        int           error_count;
        int           bytes_checked;
        int           frames_closed;

        function new();
            in_packet     = 1'b0;
            bytes_left    = 16'd0;
            running_crc   = CRC_INIT;
            error_count   = 0;
            bytes_checked = 0;
            frames_closed = 0;
        endfunction

        // Reflected CCITT, bit at a time with the 0x8408 polynomial.
        function logic [15:0] fold_crc(logic [15:0] crc, logic [7:0] data);
            logic [15:0] c;
            c = crc ^ {8'h00, data};
            for (int i = 0; i < 8; i++)
                c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
            return c;
        endfunction

        function void add_trailer(ref framed_byte_t run[$]);
            run.push_back('{running_crc[7:0], 1'b0, 1'b0});
            run.push_back('{running_crc[15:8], 1'b0, 1'b0});
            run.push_back('{STOP_OUTER, 1'b0, 1'b0});
            run.push_back('{STOP_MID, 1'b0, 1'b0});
            run.push_back('{STOP_OUTER, 1'b0, 1'b1});
            in_packet  = 1'b0;
            bytes_left = 16'd0;
        endfunction

        // Predicts the bytes that one accepted item causes; returns their count.
        function int note_item(opcode_t op, logic [7:0] pbyte, logic [15:0] len,
                               logic [7:0] desc);
            framed_byte_t run[$];
            if (op == OP_BEGIN)
            begin
                running_crc = CRC_INIT;
                run.push_back('{START_OUTER, 1'b0, 1'b0});
                run.push_back('{START_MID, 1'b0, 1'b0});
                run.push_back('{START_OUTER, 1'b0, 1'b0});
                run.push_back('{len[7:0], 1'b0, 1'b0});
                run.push_back('{len[15:8], 1'b0, 1'b0});
                run.push_back('{desc, 1'b0, 1'b0});
                if (len == 16'd0)
                    add_trailer(run);
                else
                begin
                    in_packet  = 1'b1;
                    bytes_left = len;
                end
            end
            else if (in_packet)
            begin
                running_crc = fold_crc(running_crc, pbyte);
                run.push_back('{pbyte, 1'b0, 1'b0});
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0)
                    add_trailer(run);
            end
            if (run.size() == 0)
                return 0;
            run[run.size() - 1].last_of_run = 1'b1;
            foreach (run[i])
                pending_bytes.push_back(run[i]);
            return run.size();
        endfunction

        function void check_byte(logic [7:0] value, logic last_of_run, logic frame_end);
            framed_byte_t exp_byte;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected byte %0h with no prediction waiting", value);
                error_count++;
                return;
            end
            exp_byte = pending_bytes.pop_front();
            bytes_checked++;
            if (frame_end === 1'b1)
                frames_closed++;
            if (value !== exp_byte.value)
            begin
                $error("out_byte: expected %0h, got %0h", exp_byte.value, value);
                error_count++;
            end
            if (last_of_run !== exp_byte.last_of_run)
            begin
                $error("last_of_run: expected %0b, got %0b", exp_byte.last_of_run,
                       last_of_run);
                error_count++;
            end
            if (frame_end !== exp_byte.frame_end)
            begin
                $error("frame_end: expected %0b, got %0b", exp_byte.frame_end, frame_end);
                error_count++;
            end
        endfunction

        function void check_drained();
            if (pending_bytes.size() != 0)
            begin
                $error("%0d predicted bytes never arrived", pending_bytes.size());
                error_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   items_sent;
    int   stray_items;

    framer_scoreboard framer_sb;

    crcpf_in_if  pkt_if ();
    crcpf_out_if stream_if ();

    crc16_packet_framer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pkt    (pkt_if),
        .stream (stream_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
        stream_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && stream_if.valid && stream_if.ready)
            framer_sb.check_byte(stream_if.out_byte, stream_if.last_of_run,
                                 stream_if.frame_end);
    end

    task automatic send_item(opcode_t op, logic [7:0] pbyte, logic [15:0] len,
                             logic [7:0] desc);
        int n;
        while ($urandom_range(99) < send_idle_pct)
        begin
            pkt_if.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_if.valid         <= 1'b1;
        pkt_if.opcode        <= op;
        pkt_if.payload_byte  <= pbyte;
        pkt_if.packet_length <= len;
        pkt_if.descriptor    <= desc;
        @(posedge clk);
        while (!pkt_if.ready)
            @(posedge clk);
        n = framer_sb.note_item(op, pbyte, len, desc);
        if (op == OP_BEGIN || n > 0)
            items_sent++;
        else
            stray_items++;
    endtask

    task automatic send_payloads(int count);
        for (int i = 0; i < count; i++)
            send_item(OP_PAYLOAD, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // Mostly complete packets; the rest are cut short, empty or stray bytes.
    task automatic send_random_mix(int target);
        int          pick;
        int          len;
        logic [15:0] big_len;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                send_item(OP_BEGIN, 8'($urandom), 16'(len), 8'($urandom));
                send_payloads(len);
            end
            else if (pick < 80)
            begin
                big_len = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(2, 12));
                send_item(OP_BEGIN, 8'($urandom), big_len, 8'($urandom));
                if (big_len > 16'd1)
                    send_payloads($urandom_range(0, (big_len > 16'd7) ? 6 : big_len - 1));
            end
            else if (pick < 90)
                send_item(OP_BEGIN, 8'($urandom), 16'd0, 8'($urandom));
            else
                send_payloads($urandom_range(1, 3));
        end
    endtask

    initial
    begin
        framer_sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        stray_items    = 0;
        rst_n = 1'b0;
        pkt_if.valid         <= 1'b0;
        pkt_if.opcode        <= OP_BEGIN;
        pkt_if.payload_byte  <= 8'h00;
        pkt_if.packet_length <= 16'h0000;
        pkt_if.descriptor    <= 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero-length frames with the descriptor extremes.
        send_item(OP_BEGIN, 8'h00, 16'h0000, 8'h00);
        send_item(OP_BEGIN, 8'hFF, 16'h0000, 8'hFF);
        // A payload byte with no open packet is dropped.
        send_item(OP_PAYLOAD, 8'h5A, 16'h0000, 8'h00);
        send_item(OP_BEGIN, 8'h00, 16'd3, 8'h81);
        send_item(OP_PAYLOAD, 8'h00, 16'h0000, 8'h00);
        send_item(OP_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF);
        send_item(OP_PAYLOAD, 8'h3C, 16'h0000, 8'h00);
        // Maximum length, abandoned by the next begin.
        send_item(OP_BEGIN, 8'h00, 16'hFFFF, 8'h7E);
        send_item(OP_PAYLOAD, 8'h12, 16'h0000, 8'h00);
        send_item(OP_PAYLOAD, 8'hED, 16'h0000, 8'h00);
        send_item(OP_BEGIN, 8'h00, 16'h0100, 8'h01);
        send_item(OP_PAYLOAD, 8'hAA, 16'h0000, 8'h00);
        send_item(OP_BEGIN, 8'h00, 16'd2, 8'h42);
        send_item(OP_PAYLOAD, 8'h55, 16'h0000, 8'h00);
        send_item(OP_PAYLOAD, 8'h01, 16'h0000, 8'h00);
        send_item(OP_PAYLOAD, 8'h99, 16'h0000, 8'h00);
        send_item(OP_BEGIN, 8'h00, 16'd1, 8'hC3);
        send_item(OP_PAYLOAD, 8'h80, 16'h0000, 8'h00);

        send_random_mix(ITEM_TARGET / 4);
        send_idle_pct = 49;
        send_random_mix(ITEM_TARGET / 2);
        send_idle_pct  = 0;
        recv_stall_pct = 49;
        send_random_mix(3 * ITEM_TARGET / 4);
        send_idle_pct  = 24;
        recv_stall_pct = 24;
        send_random_mix(ITEM_TARGET);
        pkt_if.valid <= 1'b0;

        while (framer_sb.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        framer_sb.check_drained();

        $display("Sent %0d framing items and %0d stray payload bytes.", items_sent,
                 stray_items);
        $display("Checked %0d framed bytes, %0d frames closed with a CRC trailer.",
                 framer_sb.bytes_checked, framer_sb.frames_closed);
        if (framer_sb.error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
